// ----- hdl/dda_pkg.sv -----
// ----------------------------------------------------------------------------
// dda_pkg
// Shared widths, types and codes for the line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_W      = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_W     = FRAC_BITS + 2;
  localparam int CNT_W      = COORD_BITS + 1;
  localparam int DIV_W      = COORD_BITS + FRAC_BITS;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int ITER_W     = $clog2(DIV_W + 1);
  localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + CNT_W + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ACC_W-1:0]      acc_t;
  typedef logic [STEP_W-1:0]     step_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DIV_W-1:0]      dividend_t;
  typedef logic [QUO_W-1:0]      quo_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_PIXEL = 1'b1
  } dda_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y
  } dda_state_t;

endpackage

// ----- hdl/dda_div.sv -----
// ----------------------------------------------------------------------------
// dda_div
// Restoring divider, one quotient bit per cycle, shared by both axes.
// ----------------------------------------------------------------------------
module dda_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dda_pkg::dividend_t dividend,
  input  dda_pkg::coord_t    divisor,
  output logic               done,
  output dda_pkg::quo_t      quotient
);
  import dda_pkg::*;

  logic                busy;
  logic [ITER_W-1:0]   cnt;
  coord_t              rem;
  coord_t              dvs;
  dividend_t           quo;
  logic [COORD_BITS:0] trial;
  logic [COORD_BITS:0] diff;
  logic                fits;

  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ITER_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo[QUO_W-1:0];

endmodule

// ----- hdl/dda_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line generator: start items load endpoints, pixel items emit pixels.
// ----------------------------------------------------------------------------
// every item gives its result item in the output register in the cycle after it is taken
// pixel items: one per cycle while the sequencer is idle and the output side takes them
// start items (unless both endpoints coincide): ready drops while the shared
//   restoring divider makes both increments, x first, then y
// reset: synchronous, clears sequencer, pixel count and output valid
// ----------------------------------------------------------------------------
module dda_line_rasterizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // x_start, y_start, x_end, y_end
  input  logic [dda_pkg::IN_DATA_W-1:0]  s_tdata,
  // command
  input  logic [0:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pixel_x, pixel_y, pixels_remaining
  output logic [dda_pkg::OUT_DATA_W-1:0] m_tdata,
  // pixel_valid
  output logic [0:0]                     m_tuser,
  output logic                           m_tlast
);
  import dda_pkg::*;

  dda_state_t state, state_next;

  acc_t   acc_x, acc_y;
  step_t  step_x, step_y;
  cnt_t   left_count;
  coord_t steps;
  coord_t mag_y;
  logic   neg_x, neg_y;

  coord_t out_x, out_y;
  cnt_t   out_cnt;
  logic   out_valid, out_last;

  logic      in_fire;
  dda_cmd_t  cmd;
  coord_t    xs, ys, xe, ye, adx, ady, steps_in;
  cnt_t      cnt_start, cnt_dec;
  acc_t      round_x, round_y;
  logic      div_start, div_done;
  dividend_t div_dividend;
  coord_t    div_divisor;
  quo_t      quotient;
  step_t     quo_signed;

  always_comb begin
    s_tready  = (state == ST_IDLE) && (!m_tvalid || m_tready);
    in_fire   = s_tvalid && s_tready;
    cmd       = dda_cmd_t'(s_tuser[0]);
    xs        = s_tdata[0 +: COORD_BITS];
    ys        = s_tdata[COORD_BITS +: COORD_BITS];
    xe        = s_tdata[2*COORD_BITS +: COORD_BITS];
    ye        = s_tdata[3*COORD_BITS +: COORD_BITS];
    adx       = (xe >= xs) ? xe - xs : xs - xe;
    ady       = (ye >= ys) ? ye - ys : ys - ye;
    steps_in  = (adx >= ady) ? adx : ady;
    cnt_start = {1'b0, steps_in} + 1'b1;
    cnt_dec   = left_count - 1'b1;
    round_x   = acc_x + (ACC_W'(1) << (FRAC_BITS - 1));
    round_y   = acc_y + (ACC_W'(1) << (FRAC_BITS - 1));
  end

  // sequencer
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = {mag_y, {FRAC_BITS{1'b0}}};
    div_divisor  = steps;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && cmd == CMD_START && steps_in != '0) begin
          state_next   = ST_DIV_X;
          div_start    = 1'b1;
          div_dividend = {adx, {FRAC_BITS{1'b0}}};
          div_divisor  = steps_in;
        end
      end
      ST_DIV_X: begin
        if (div_done) begin
          state_next = ST_DIV_Y;
          div_start  = 1'b1;
        end
      end
      ST_DIV_Y: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  dda_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    quo_signed = {1'b0, quotient};
    if ((state == ST_DIV_X) ? neg_x : neg_y) begin
      quo_signed = '0 - {1'b0, quotient};
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count <= '0;
    end else if (in_fire) begin
      if (cmd == CMD_START) begin
        left_count <= cnt_start;
      end else if (left_count != '0) begin
        left_count <= cnt_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && cmd == CMD_START) begin
      acc_x  <= {1'b0, xs, {FRAC_BITS{1'b0}}};
      acc_y  <= {1'b0, ys, {FRAC_BITS{1'b0}}};
      steps  <= steps_in;
      mag_y  <= ady;
      neg_x  <= xe < xs;
      neg_y  <= ye < ys;
      step_x <= '0;
      step_y <= '0;
    end else begin
      if (in_fire && left_count != '0) begin
        acc_x <= acc_x + {{(ACC_W-STEP_W){step_x[STEP_W-1]}}, step_x};
        acc_y <= acc_y + {{(ACC_W-STEP_W){step_y[STEP_W-1]}}, step_y};
      end
      if (div_done && state == ST_DIV_X) begin
        step_x <= quo_signed;
      end
      if (div_done && state == ST_DIV_Y) begin
        step_y <= quo_signed;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_valid <= 1'b0;
      out_x     <= '0;
      out_y     <= '0;
      out_last  <= 1'b0;
      out_cnt   <= '0;
      if (cmd == CMD_START) begin
        out_cnt <= cnt_start;
      end else if (left_count != '0) begin
        out_valid <= 1'b1;
        out_x     <= round_x[FRAC_BITS +: COORD_BITS];
        out_y     <= round_y[FRAC_BITS +: COORD_BITS];
        out_last  <= cnt_dec == '0;
        out_cnt   <= cnt_dec;
      end
    end
  end

  assign m_tdata    = OUT_DATA_W'({out_cnt, out_y, out_x});
  assign m_tuser[0] = out_valid;
  assign m_tlast    = out_last;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_tready)
    else $error("input taken while increments are being computed");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_X || state == ST_DIV_Y))
    else $error("divider finished outside a division state");

  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0] && out_cnt == '0 && left_count == '0)
    else $error("last pixel with pixels still pending");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    left_count <= cnt_t'(1 << COORD_BITS))
    else $error("pixel count out of range");

endmodule
